### rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants for the sortable record stack.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int MODE_W          = 3;
    localparam int STATUS_W        = 2;
    localparam int COUNT_OUT_W     = 7;

    localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SORT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] CODE_NONE = '1;

    typedef struct packed {
        logic [DATA_W-1:0] code;
        logic [DATA_W-1:0] quantity;
        logic [DATA_W-1:0] price;
    } record_t;

endpackage

### rtl/sortable_record_stack.sv
// Sort: insertion sort; each compare reads an adjacent record pair, and a swap
// also writes the pair back. One item at a time; the next is taken once the
// result has been taken.
// Reset (rst_n, async low) empties the stack; memory contents are not cleared.
// ----------------------------------------------------------------------------
// sortable_record_stack
// LIFO record stack with search, stable sort and reverse, run by a sequencer
// over one memory (one write, one read port) and one less-than code comparator for sort.
// ----------------------------------------------------------------------------
module sortable_record_stack
    import srs_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [MODE_W-1:0]       mode,
    input  logic signed [DATA_W-1:0] item_code,
    input  logic signed [DATA_W-1:0] item_quantity,
    input  logic [DATA_W-1:0]       item_price_bits,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [DATA_W-1:0] out_code,
    output logic signed [DATA_W-1:0] out_quantity,
    output logic [DATA_W-1:0]       out_price_bits,
    output logic                    found,
    output logic [STATUS_W-1:0]     status,
    output logic [COUNT_OUT_W-1:0]  depth_count
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_POP_RD, S_POP_WAIT, S_SRCH_RD, S_SRCH_CMP,
        S_SW_RDA, S_SW_RDB, S_SW_WAIT, S_SW_WRA, S_SW_WRB, S_DONE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [MODE_W-1:0]    op_reg;
    logic [DATA_W-1:0]    key_reg;
    logic [CNT_W-1:0]     i_reg;     // sort outer index / search index / reverse lo
    logic [CNT_W-1:0]     j_reg;     // sort inner index / reverse hi
    record_t              ra_reg, rb_reg;
    logic                 hit_reg;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    record_t              wr_data, rd_data;

    srs_store #(.STACK_DEPTH(STACK_DEPTH), .ADDR_W(ADDR_W)) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // sort comparator: signed less-than on codes
    logic cmp_less;
    assign cmp_less = $signed(ra_reg.code) < $signed(rd_data.code);

    // the pair addressed by a swap step: a = lower index, b = upper index
    logic [CNT_W-1:0] a_idx, b_idx;
    always_comb
    begin
        if (op_reg == MODE_SORT)
        begin
            a_idx = j_reg - CNT_W'(1);
            b_idx = j_reg;
        end
        else
        begin
            a_idx = i_reg;
            b_idx = j_reg;
        end
    end

    always_comb
    begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = ra_reg;
        case (state_reg)
            S_IDLE:
            begin
                wr_en   = in_valid && in_ready && mode == MODE_PUSH && fill_reg < DEPTH_C;
                wr_addr = fill_reg[ADDR_W-1:0];
                wr_data = '{code: item_code, quantity: item_quantity,
                            price: item_price_bits};
            end
            S_POP_RD:   rd_addr = fill_reg[ADDR_W-1:0];
            S_SRCH_RD:  rd_addr = i_reg[ADDR_W-1:0];
            S_SW_RDA:   rd_addr = a_idx[ADDR_W-1:0];
            S_SW_RDB:   rd_addr = b_idx[ADDR_W-1:0];
            S_SW_WRA:
            begin
                wr_en   = 1'b1;
                wr_addr = a_idx[ADDR_W-1:0];
                wr_data = rb_reg;
            end
            S_SW_WRB:
            begin
                wr_en   = 1'b1;
                wr_addr = b_idx[ADDR_W-1:0];
                wr_data = ra_reg;
            end
            default: ;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE) && !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            out_valid      <= 1'b0;
            op_reg         <= MODE_PUSH;
            i_reg          <= '0;
            j_reg          <= '0;
            hit_reg        <= 1'b0;
            key_reg        <= '0;
            ra_reg         <= '0;
            rb_reg         <= '0;
            out_code       <= '0;
            out_quantity   <= '0;
            out_price_bits <= '0;
            found          <= 1'b0;
            status         <= ST_OK;
            depth_count    <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        op_reg         <= mode;
                        key_reg        <= item_code;
                        hit_reg        <= 1'b0;
                        out_code       <= CODE_NONE;
                        out_quantity   <= '0;
                        out_price_bits <= '0;
                        found          <= 1'b0;
                        status         <= ST_OK;
                        state_reg      <= S_DONE;
                        case (mode)
                            MODE_PUSH:
                            begin
                                if (fill_reg < DEPTH_C)
                                    fill_reg <= fill_reg + CNT_W'(1);
                                else
                                    status <= ST_FULL;
                            end
                            MODE_POP:
                            begin
                                if (fill_reg == '0)
                                    status <= ST_EMPTY;
                                else
                                begin
                                    fill_reg  <= fill_reg - CNT_W'(1);
                                    state_reg <= S_POP_RD;
                                end
                            end
                            MODE_SEARCH:
                            begin
                                i_reg <= '0;
                                if (fill_reg != '0)
                                    state_reg <= S_SRCH_RD;
                            end
                            MODE_SORT:
                            begin
                                i_reg <= CNT_W'(1);
                                j_reg <= CNT_W'(1);
                                if (fill_reg > CNT_W'(1))
                                    state_reg <= S_SW_RDA;
                            end
                            MODE_REVERSE:
                            begin
                                i_reg <= '0;
                                j_reg <= fill_reg - CNT_W'(1);
                                if (fill_reg > CNT_W'(1))
                                    state_reg <= S_SW_RDA;
                            end
                            default: ;
                        endcase
                    end
                end
                S_POP_RD:   state_reg <= S_POP_WAIT;
                S_POP_WAIT:
                begin
                    out_code       <= rd_data.code;
                    out_quantity   <= rd_data.quantity;
                    out_price_bits <= rd_data.price;
                    state_reg      <= S_DONE;
                end
                S_SRCH_RD:  state_reg <= S_SRCH_CMP;
                S_SRCH_CMP:
                begin
                    if (rd_data.code == key_reg || hit_reg)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (i_reg + CNT_W'(1) >= fill_reg)
                    begin
                        found     <= hit_reg || rd_data.code == key_reg;
                        out_code  <= (hit_reg || rd_data.code == key_reg) ? key_reg
                                                                          : CODE_NONE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_SW_RDA:   state_reg <= S_SW_RDB;
                S_SW_RDB:
                begin
                    ra_reg    <= rd_data;
                    state_reg <= S_SW_WAIT;
                end
                S_SW_WAIT:
                begin
                    rb_reg <= rd_data;
                    if (op_reg == MODE_REVERSE || cmp_less)
                        state_reg <= S_SW_WRA;
                    else
                    begin
                        // no swap: insertion of this element ends, take next
                        if (i_reg + CNT_W'(1) >= fill_reg)
                            state_reg <= S_DONE;
                        else
                        begin
                            i_reg     <= i_reg + CNT_W'(1);
                            j_reg     <= i_reg + CNT_W'(1);
                            state_reg <= S_SW_RDA;
                        end
                    end
                end
                S_SW_WRA:   state_reg <= S_SW_WRB;
                S_SW_WRB:
                begin
                    if (op_reg == MODE_REVERSE)
                    begin
                        i_reg <= i_reg + CNT_W'(1);
                        j_reg <= j_reg - CNT_W'(1);
                        if (i_reg + CNT_W'(1) < j_reg - CNT_W'(1))
                            state_reg <= S_SW_RDA;
                        else
                            state_reg <= S_DONE;
                    end
                    else if (j_reg > CNT_W'(1))
                    begin
                        j_reg     <= j_reg - CNT_W'(1);
                        state_reg <= S_SW_RDA;
                    end
                    else if (i_reg + CNT_W'(1) >= fill_reg)
                        state_reg <= S_DONE;
                    else
                    begin
                        i_reg     <= i_reg + CNT_W'(1);
                        j_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_SW_RDA;
                    end
                end
                S_DONE:
                begin
                    depth_count <= COUNT_OUT_W'(fill_reg);
                    out_valid   <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // stack never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= DEPTH_C)
        else $error("fill count above depth");

    // an accepted push on a non-full stack grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode == MODE_PUSH && fill_reg < DEPTH_C)
        |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("push did not grow stack");

    // no input accepted while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken with result pending");

    // a result is only raised from the finishing step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("result raised out of sequence");

endmodule

### rtl/srs_store.sv
// ----------------------------------------------------------------------------
// srs_store
// Record memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srs_store
    import srs_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(STACK_DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  record_t           wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output record_t           rd_data
);

    record_t mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
